// ----- sv/digitizer_event_word_parser_top_defines.svh -----
// Assertion macros shared by the event word parser modules.
// The including module must have the ports i_clk and i_rst_n.
`ifndef DIGITIZER_EVENT_WORD_PARSER_TOP_DEFINES_SVH
`define DIGITIZER_EVENT_WORD_PARSER_TOP_DEFINES_SVH

// Checked on every clock edge outside reset.
`define DEWP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("dewp assertion failed");

// Checked on every clock edge, reset included.
`define DEWP_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) (prop)) \
        else $error("dewp reset assertion failed");

`endif

// ----- sv/dewp_pkg.sv -----
// Package of the digitizer event word parser: parse phases, result kinds,
// configuration and result types. No dependencies.
package dewp_pkg;

    localparam logic [31:0] END_MARK     = 32'h0E0F0E0F;
    localparam int          TDATA_W      = 136;
    localparam int          TUSER_W      = 4;

    typedef enum logic [3:0] {
        PH_FILE  = 4'd0,
        PH_SPILL = 4'd1,
        PH_PKT   = 4'd2,
        PH_CHAN  = 4'd3,
        PH_EV0   = 4'd4,
        PH_EV1   = 4'd5,
        PH_BLK0  = 4'd6,
        PH_BLK1  = 4'd7,
        PH_BLK2  = 4'd8,
        PH_BLK3  = 4'd9,
        PH_COUNT = 4'd10,
        PH_SAMP  = 4'd11,
        PH_DONE  = 4'd12
    } t_phase;

    localparam logic [3:0] KIND_HEAD   = 4'd0;
    localparam logic [3:0] KIND_PEAK   = 4'd1;
    localparam logic [3:0] KIND_ACC0   = 4'd2;
    localparam logic [3:0] KIND_ACC    = 4'd3;
    localparam logic [3:0] KIND_FILTER = 4'd4;
    localparam logic [3:0] KIND_ENERGY = 4'd5;
    localparam logic [3:0] KIND_COUNT  = 4'd6;
    localparam logic [3:0] KIND_SAMPLE = 4'd7;
    localparam logic [3:0] KIND_END    = 4'd8;

    localparam logic [2:0] CFG_FILE_HDR  = 3'd0;
    localparam logic [2:0] CFG_SPILL_HDR = 3'd1;
    localparam logic [2:0] CFG_PKT_HDR   = 3'd2;
    localparam logic [2:0] CFG_CHAN_HDR  = 3'd3;
    localparam logic [2:0] CFG_CHANS     = 3'd4;
    localparam logic [2:0] CFG_CARDS     = 3'd5;

    typedef struct packed {
        logic [15:0] file_header_words;
        logic [7:0]  spill_header_words;
        logic [7:0]  packet_header_words;
        logic [7:0]  channel_header_words;
        logic [4:0]  channels_per_card;
        logic [3:0]  cards_per_spill;
    } t_cfg;

    typedef struct packed {
        logic [3:0]         kind;
        logic [11:0]        channel;
        logic [3:0]         format;
        logic [47:0]        primary;
        logic [31:0]        secondary;
        logic [2:0]         slot;
        logic signed [15:0] sample_low;
        logic signed [15:0] sample_high;
        logic               pileup;
        logic               maw_test;
        logic               end_of_event;
        logic               overrun;
    } t_result;

endpackage

// ----- sv/dewp_parser.sv -----
// Parse state and per-word decode of the event word parser.
// Depends on dewp_pkg and the assertion macro header.
`include "digitizer_event_word_parser_top_defines.svh"

module dewp_parser
    import dewp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic [31:0] i_word,
    input  logic        i_first,
    input  t_cfg        i_cfg,
    output logic        o_has_result,
    output t_result     o_result
);

    t_phase      r_phase, n_phase;
    logic [15:0] r_swc, n_swc;
    logic [3:0]  r_chc, n_chc;
    logic [2:0]  r_cdc, n_cdc;
    logic [31:0] r_pwl, n_pwl;
    logic [31:0] r_ehw, n_ehw;
    logic [3:0]  r_fmt, n_fmt;
    logic [2:0]  r_bwi, n_bwi;
    logic [25:0] r_swl, n_swl;
    logic        r_ovr, n_ovr;

    logic [7:0]  w_spill_len;
    logic [7:0]  w_chan_len;
    logic [4:0]  w_chans;
    logic [3:0]  w_cards;
    logic [16:0] w_swc_inc;
    logic [4:0]  w_chc_inc;
    logic [3:0]  w_cdc_inc;
    logic [3:0]  w_bwi_inc;
    logic        v_ev, v_nc, v_ee, v_gb;
    logic [2:0]  v_gb_first;

    function automatic t_phase f_goto(input logic [3:0] fmt, input logic [2:0] first);
        t_phase ph;
        ph = PH_COUNT;
        for (int b = 3; b >= 0; b--) begin
            if (fmt[b] && (3'(b) >= first)) begin
                ph = t_phase'(4'(int'(PH_BLK0) + b));
            end
        end
        return ph;
    endfunction

    assign w_spill_len = (i_cfg.spill_header_words == 8'd0) ? 8'd1 : i_cfg.spill_header_words;
    assign w_chan_len  = (i_cfg.channel_header_words == 8'd0) ? 8'd1
                                                               : i_cfg.channel_header_words;
    assign w_chans = (i_cfg.channels_per_card == 5'd0) ? 5'd1 :
                     ((i_cfg.channels_per_card > 5'd16) ? 5'd16 : i_cfg.channels_per_card);
    assign w_cards = (i_cfg.cards_per_spill == 4'd0) ? 4'd1 :
                     ((i_cfg.cards_per_spill > 4'd8) ? 4'd8 : i_cfg.cards_per_spill);

    always_comb begin
        n_phase = r_phase;
        n_swc   = r_swc;
        n_chc   = r_chc;
        n_cdc   = r_cdc;
        n_pwl   = r_pwl;
        n_ehw   = r_ehw;
        n_fmt   = r_fmt;
        n_bwi   = r_bwi;
        n_swl   = r_swl;
        n_ovr   = r_ovr;
        o_has_result = 1'b0;
        o_result     = '0;
        v_ev = 1'b0;
        v_nc = 1'b0;
        v_ee = 1'b0;
        v_gb = 1'b0;
        v_gb_first = 3'd0;

        if (i_first) begin
            n_phase = PH_FILE;
            n_swc   = '0;
            n_chc   = '0;
            n_cdc   = '0;
            n_pwl   = '0;
            n_ehw   = '0;
            n_fmt   = '0;
            n_bwi   = '0;
            n_swl   = '0;
            n_ovr   = 1'b0;
        end
        if (n_phase == PH_FILE && i_cfg.file_header_words == 16'd0) begin
            n_phase = PH_SPILL;
            n_swc   = '0;
        end
        if (n_phase == PH_PKT && i_cfg.packet_header_words == 8'd0) begin
            n_phase = PH_CHAN;
            n_swc   = '0;
        end

        if (n_phase == PH_EV0) begin
            n_ovr = 1'b0;
        end
        if (n_phase inside {[PH_EV0:PH_SAMP]}) begin
            if (n_pwl != 32'd0) begin
                n_pwl = n_pwl - 32'd1;
            end else begin
                n_ovr = 1'b1;
            end
        end

        w_swc_inc = {1'b0, n_swc} + 17'd1;
        w_bwi_inc = {1'b0, n_bwi} + 4'd1;

        unique case (n_phase)
            PH_FILE: begin
                if (w_swc_inc >= 17'(i_cfg.file_header_words)) begin
                    n_swc   = '0;
                    n_phase = PH_SPILL;
                end else begin
                    n_swc = w_swc_inc[15:0];
                end
            end
            PH_SPILL: begin
                if (n_swc == 16'd0 && i_word == END_MARK) begin
                    n_phase       = PH_DONE;
                    o_has_result  = 1'b1;
                    o_result.kind = KIND_END;
                end else if (w_swc_inc >= 17'(w_spill_len)) begin
                    n_swc   = '0;
                    n_chc   = '0;
                    n_cdc   = '0;
                    n_phase = (i_cfg.packet_header_words == 8'd0) ? PH_CHAN : PH_PKT;
                end else begin
                    n_swc = w_swc_inc[15:0];
                end
            end
            PH_PKT: begin
                if (w_swc_inc >= 17'(i_cfg.packet_header_words)) begin
                    n_swc   = '0;
                    n_phase = PH_CHAN;
                end else begin
                    n_swc = w_swc_inc[15:0];
                end
            end
            PH_CHAN: begin
                if (w_swc_inc >= 17'(w_chan_len)) begin
                    n_swc = '0;
                    n_pwl = i_word;
                    if (i_word == 32'd0) begin
                        v_nc = 1'b1;
                    end else begin
                        n_phase = PH_EV0;
                    end
                end else begin
                    n_swc = w_swc_inc[15:0];
                end
            end
            PH_EV0: begin
                n_ehw   = i_word;
                n_fmt   = i_word[3:0];
                n_phase = PH_EV1;
            end
            PH_EV1: begin
                v_ev             = 1'b1;
                o_result.kind    = KIND_HEAD;
                o_result.primary = {n_ehw[31:16], i_word};
                v_gb             = 1'b1;
                v_gb_first       = 3'd0;
            end
            PH_BLK0: begin
                v_ev = 1'b1;
                if (n_bwi == 3'd0) begin
                    o_result.kind      = KIND_PEAK;
                    o_result.primary   = 48'(i_word[15:0]);
                    o_result.secondary = 32'(i_word[31:16]);
                end else if (n_bwi == 3'd1) begin
                    o_result.kind      = KIND_ACC0;
                    o_result.primary   = 48'(i_word[23:0]);
                    o_result.secondary = 32'(i_word[31:24]);
                end else begin
                    o_result.kind    = KIND_ACC;
                    o_result.primary = 48'(i_word);
                    o_result.slot    = n_bwi - 3'd1;
                end
                n_bwi = w_bwi_inc[2:0];
                if (w_bwi_inc >= 4'd7) begin
                    v_gb       = 1'b1;
                    v_gb_first = 3'd1;
                end
            end
            PH_BLK1: begin
                v_ev             = 1'b1;
                o_result.kind    = KIND_ACC;
                o_result.primary = 48'(i_word);
                o_result.slot    = 3'd6 + n_bwi;
                n_bwi            = w_bwi_inc[2:0];
                if (w_bwi_inc >= 4'd2) begin
                    v_gb       = 1'b1;
                    v_gb_first = 3'd2;
                end
            end
            PH_BLK2: begin
                v_ev             = 1'b1;
                o_result.kind    = KIND_FILTER;
                o_result.primary = 48'(i_word);
                o_result.slot    = n_bwi;
                n_bwi            = w_bwi_inc[2:0];
                if (w_bwi_inc >= 4'd3) begin
                    v_gb       = 1'b1;
                    v_gb_first = 3'd3;
                end
            end
            PH_BLK3: begin
                v_ev             = 1'b1;
                o_result.kind    = KIND_ENERGY;
                o_result.primary = 48'(i_word);
                o_result.slot    = n_bwi;
                n_bwi            = w_bwi_inc[2:0];
                if (w_bwi_inc >= 4'd2) begin
                    v_gb       = 1'b1;
                    v_gb_first = 3'd4;
                end
            end
            PH_COUNT: begin
                v_ev                  = 1'b1;
                n_swl                 = i_word[25:0];
                o_result.kind         = KIND_COUNT;
                o_result.primary      = 48'({i_word[25:0], 1'b0});
                o_result.pileup       = i_word[26];
                o_result.maw_test     = i_word[27];
                o_result.end_of_event = (i_word[25:0] == 26'd0);
                if (i_word[25:0] == 26'd0) begin
                    v_ee = 1'b1;
                end else begin
                    n_phase = PH_SAMP;
                end
            end
            PH_SAMP: begin
                v_ev = 1'b1;
                if (n_swl != 26'd0) begin
                    n_swl = n_swl - 26'd1;
                end
                o_result.kind         = KIND_SAMPLE;
                o_result.sample_low   = i_word[15:0];
                o_result.sample_high  = i_word[31:16];
                o_result.end_of_event = (n_swl == 26'd0);
                if (n_swl == 26'd0) begin
                    v_ee = 1'b1;
                end
            end
            PH_DONE: begin
            end
            default: begin
            end
        endcase

        if (v_ev) begin
            o_has_result     = 1'b1;
            o_result.channel = n_ehw[15:4];
            o_result.format  = n_ehw[3:0];
            o_result.overrun = n_ovr;
        end
        if (v_gb) begin
            n_bwi   = '0;
            n_phase = f_goto(n_fmt, v_gb_first);
        end
        if (v_ee) begin
            if (n_pwl != 32'd0) begin
                n_phase = PH_EV0;
            end else begin
                v_nc = 1'b1;
            end
        end

        w_chc_inc = {1'b0, n_chc} + 5'd1;
        w_cdc_inc = {1'b0, n_cdc} + 4'd1;
        if (v_nc) begin
            n_swc   = '0;
            n_phase = PH_CHAN;
            n_chc   = w_chc_inc[3:0];
            if (w_chc_inc >= w_chans) begin
                n_chc = '0;
                n_cdc = w_cdc_inc[2:0];
                if (w_cdc_inc >= w_cards) begin
                    n_cdc   = '0;
                    n_phase = PH_SPILL;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FILE;
            r_swc   <= '0;
            r_chc   <= '0;
            r_cdc   <= '0;
            r_pwl   <= '0;
            r_ehw   <= '0;
            r_fmt   <= '0;
            r_bwi   <= '0;
            r_swl   <= '0;
            r_ovr   <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_swc   <= n_swc;
            r_chc   <= n_chc;
            r_cdc   <= n_cdc;
            r_pwl   <= n_pwl;
            r_ehw   <= n_ehw;
            r_fmt   <= n_fmt;
            r_bwi   <= n_bwi;
            r_swl   <= n_swl;
            r_ovr   <= n_ovr;
        end
    end

    `DEWP_ASSERT(a_kind_range, (i_step && o_has_result) |-> (o_result.kind <= KIND_END))
    `DEWP_ASSERT(a_end_stops, (i_step && o_has_result && o_result.kind == KIND_END) |=> (r_phase == PH_DONE))
    `DEWP_ASSERT(a_last_pair, (i_step && o_has_result && o_result.kind == KIND_SAMPLE && o_result.end_of_event) |=> (r_phase != PH_SAMP))

endmodule

// ----- sv/dewp_out_stage.sv -----
// Result register of the event word parser and packing onto the master stream.
// Depends on dewp_pkg.
module dewp_out_stage
    import dewp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic               i_has_result,
    input  t_result            i_result,
    output logic               o_ready,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [TDATA_W-1:0] o_m_tdata,
    output logic [TUSER_W-1:0] o_m_tuser,
    output logic               o_m_tlast
);

    logic    r_valid;
    t_result r_res;

    assign o_ready = !r_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_step && i_has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_step && i_has_result) begin
            r_res <= i_result;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tuser  = r_res.kind;
    assign o_m_tlast  = r_res.end_of_event;
    assign o_m_tdata  = {2'b00, r_res.overrun, r_res.maw_test, r_res.pileup,
                         r_res.sample_high, r_res.sample_low, r_res.slot,
                         r_res.secondary, r_res.primary, r_res.format, r_res.channel};

endmodule

// ----- sv/digitizer_event_word_parser_top.sv -----
// Top level of the digitizer event word parser: input register, configuration
// registers, parser and result register. Depends on dewp_pkg, dewp_parser,
// dewp_out_stage and the assertion macro header.
//
// The slave stream takes the record file one word per transfer: tdata holds the
// 32-bit file word, tuser is set on the first word of a file and restarts parsing
// at the file header. The master stream gives at most one result per input word:
// tuser holds the kind, tlast marks the last result of an event, and tdata holds
// from the lowest bit up channel, format, primary, secondary, slot, sample_low,
// sample_high, pileup, maw_test and overrun. Words that are skipped or consumed
// by headers give no result.
// A word is decoded in the cycle after it is accepted and its result is registered as
// the word steps the parser. While results are taken, one word is accepted per cycle
// and the parse state advances one word per cycle through a single decode step.
// When the receiver stalls, the result register holds and the input register still
// takes one more word; then the slave side stalls until the result is taken.
// Reset clears both registers, loads the default configuration and puts the parser
// into the file header. Configuration writes take effect at the next clock edge.
`include "digitizer_event_word_parser_top_defines.svh"

module digitizer_event_word_parser_top
    import dewp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic [31:0]        i_s_tdata,  // data_word
    input  logic               i_s_tuser,  // first_of_file
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [TDATA_W-1:0] o_m_tdata,  // channel, format, primary, secondary, slot,
                                           // sample_low, sample_high, pileup, maw_test,
                                           // overrun, zero fill
    output logic [TUSER_W-1:0] o_m_tuser,  // kind
    output logic               o_m_tlast,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    logic        r_in_valid;
    logic [31:0] r_in_word;
    logic        r_in_first;
    t_cfg        r_cfg;
    logic        w_out_ready;
    logic        w_step;
    logic        w_has_result;
    t_result     w_result;

    assign w_step     = r_in_valid && w_out_ready;
    assign o_s_tready = !r_in_valid || w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_word  <= i_s_tdata;
            r_in_first <= i_s_tuser;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.file_header_words    <= 16'd100;
            r_cfg.spill_header_words   <= 8'd10;
            r_cfg.packet_header_words  <= 8'd2;
            r_cfg.channel_header_words <= 8'd8;
            r_cfg.channels_per_card    <= 5'd16;
            r_cfg.cards_per_spill      <= 4'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FILE_HDR:  r_cfg.file_header_words    <= i_cfg_data;
                CFG_SPILL_HDR: r_cfg.spill_header_words   <= i_cfg_data[7:0];
                CFG_PKT_HDR:   r_cfg.packet_header_words  <= i_cfg_data[7:0];
                CFG_CHAN_HDR:  r_cfg.channel_header_words <= i_cfg_data[7:0];
                CFG_CHANS:     r_cfg.channels_per_card    <= i_cfg_data[4:0];
                CFG_CARDS:     r_cfg.cards_per_spill      <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    dewp_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_step),
        .i_word       (r_in_word),
        .i_first      (r_in_first),
        .i_cfg        (r_cfg),
        .o_has_result (w_has_result),
        .o_result     (w_result)
    );

    dewp_out_stage u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_step),
        .i_has_result (w_has_result),
        .i_result     (w_result),
        .o_ready      (w_out_ready),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_m_tdata    (o_m_tdata),
        .o_m_tuser    (o_m_tuser),
        .o_m_tlast    (o_m_tlast)
    );

    `DEWP_ASSERT(a_full_stall, (r_in_valid && o_m_tvalid && !i_m_tready) |-> !o_s_tready)
    `DEWP_ASSERT(a_step_drains, (w_step && !(i_s_tvalid && o_s_tready)) |=> !r_in_valid)
    `DEWP_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> (!o_m_tvalid && !r_in_valid))

endmodule
